[rtl/core/dshot_pkg.sv]
`timescale 1ns / 1ps

package dshot_pkg;

    localparam int DURATION_BITS_DEF = 15;
    localparam int BIT_NS            = 2667;
    localparam int TICK_NS           = 50;
    localparam int WORD_BITS         = 21;
    localparam int CNT_W             = 5;
    localparam int SYM_W             = 6;
    localparam int PERIOD_W          = 16;
    localparam int MAX_SYM_RESET     = 12;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic [SYM_W-1:0] SYM_SAT = '1;

    localparam logic [1:0] ST_ECHO    = 2'd0;
    localparam logic [1:0] ST_PERIOD  = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [0:0] REG_MAX_SYMBOLS = 1'd0;

    typedef struct packed {
        logic             zero;
        logic             level;
        logic [CNT_W-1:0] cnt;
    } t_run;

    typedef struct packed {
        logic [WORD_BITS-1:0] acc;
        logic [CNT_W-1:0]     bc;
        logic                 failed;
        logic                 echo;
    } t_capture;

    // smallest duration in ticks that rounds to at least k bits
    function automatic int run_threshold(input int k);
        int num;
        begin
            num = BIT_NS * k - BIT_NS / 2;
            return (num + TICK_NS - 1) / TICK_NS;
        end
    endfunction

    // {code valid, nibble}
    function automatic logic [4:0] gcr_lookup(input logic [4:0] code);
        logic [4:0] r;
        begin
            case (code)
                5'h09: r = {1'b1, 4'd9};
                5'h0A: r = {1'b1, 4'd10};
                5'h0B: r = {1'b1, 4'd11};
                5'h0D: r = {1'b1, 4'd13};
                5'h0E: r = {1'b1, 4'd14};
                5'h0F: r = {1'b1, 4'd15};
                5'h12: r = {1'b1, 4'd2};
                5'h13: r = {1'b1, 4'd3};
                5'h15: r = {1'b1, 4'd5};
                5'h16: r = {1'b1, 4'd6};
                5'h17: r = {1'b1, 4'd7};
                5'h19: r = {1'b1, 4'd0};
                5'h1A: r = {1'b1, 4'd8};
                5'h1B: r = {1'b1, 4'd1};
                5'h1D: r = {1'b1, 4'd4};
                5'h1E: r = {1'b1, 4'd12};
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/core/dshot_erpm_reply_decoder.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// symbol    in         i_valid / o_ready   first/second level+duration, last_symbol
// result    out        o_valid / i_ready   status, period_us
// config    in         APB psel/penable    max_reply_symbols at byte 0
//
// One symbol accepted per cycle while o_ready is high; a result leaves through the run, capture and output registers.
// Per-symbol rate is set by the word packing step, which holds the
// capture state; run rounding (two lanes) and GCR/XOR checksum decoding are registered apart.
// Synchronous active-low reset empties all stages and sets max_reply_symbols to 12.
// A stalled result holds the output register; back-pressure reaches o_ready the same cycle.

module dshot_erpm_reply_decoder
    import dshot_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_first_level,
    input  logic [DURATION_BITS-1:0] i_first_duration,
    input  logic                     i_second_level,
    input  logic [DURATION_BITS-1:0] i_second_duration,
    input  logic                     i_last_symbol,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic [PERIOD_W-1:0]      o_period_us,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready
);

    logic [SYM_W-1:0]    r_max;
    logic                r_v1;
    t_run                r_run_a, r_run_b;
    logic                r_last;
    logic                r_vf;
    t_capture            r_cap;
    logic                r_vo;
    logic [1:0]          r_status;
    logic [PERIOD_W-1:0] r_period;

    t_run                run_a, run_b;
    t_capture            cap;
    logic [1:0]          fin_status;
    logic [PERIOD_W-1:0] fin_period;
    logic                go_o, fin_free, s2_take, s1_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_SYMBOLS) ? CFG_DATA_W'(r_max) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= SYM_W'(MAX_SYM_RESET);
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_SYMBOLS) begin
            r_max <= pwdata[SYM_W-1:0];
        end
    end

    dshot_run_lane #(.DURATION_BITS(DURATION_BITS)) u_lane_a (
        .i_level    (i_first_level),
        .i_duration (i_first_duration),
        .o_run      (run_a)
    );

    dshot_run_lane #(.DURATION_BITS(DURATION_BITS)) u_lane_b (
        .i_level    (i_second_level),
        .i_duration (i_second_duration),
        .o_run      (run_b)
    );

    assign go_o     = r_vf && (!r_vo || i_ready);
    assign fin_free = !r_vf || go_o;
    assign s2_take  = r_v1 && (!r_last || fin_free);
    assign s1_free  = !r_v1 || s2_take;
    assign o_ready  = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_free) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_run_a <= run_a;
            r_run_b <= run_b;
            r_last  <= i_last_symbol;
        end
    end

    dshot_word_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (s2_take),
        .i_run_a       (r_run_a),
        .i_run_b       (r_run_b),
        .i_last        (r_last),
        .i_max_symbols (r_max),
        .o_capture     (cap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (fin_free) begin
            r_vf <= s2_take && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_free && s2_take && r_last) begin
            r_cap <= cap;
        end
    end

    dshot_finish u_finish (
        .i_capture (r_cap),
        .o_status  (fin_status),
        .o_period  (fin_period)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (go_o) begin
            r_vo <= 1'b1;
        end else if (i_ready) begin
            r_vo <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go_o) begin
            r_status <= fin_status;
            r_period <= fin_period;
        end
    end

    assign o_valid     = r_vo;
    assign o_status    = r_status;
    assign o_period_us = r_period;

endmodule

[rtl/core/dshot_run_lane.sv]
`timescale 1ns / 1ps

module dshot_run_lane
    import dshot_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     i_level,
    input  logic [DURATION_BITS-1:0] i_duration,
    output t_run                     o_run
);

    localparam int CMP_W = 17;

    logic [CMP_W-1:0]     dur_ext;
    logic [WORD_BITS-1:0] thermo;
    logic [CNT_W-1:0]     cnt;

    assign dur_ext = CMP_W'(i_duration);

    for (genvar k = 1; k <= WORD_BITS; k++) begin : g_thr
        assign thermo[k-1] = (dur_ext >= CMP_W'(run_threshold(k)));
    end

    assign cnt = CNT_W'($countones(thermo));

    always_comb begin
        o_run.zero  = (i_duration == '0);
        o_run.level = i_level;
        o_run.cnt   = (cnt == '0) ? CNT_W'(1) : cnt;
    end

endmodule

[rtl/core/dshot_word_pack.sv]
`timescale 1ns / 1ps

module dshot_word_pack
    import dshot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  t_run              i_run_a,
    input  t_run              i_run_b,
    input  logic              i_last,
    input  logic [SYM_W-1:0]  i_max_symbols,
    output t_capture          o_capture
);

    typedef struct packed {
        logic [WORD_BITS-1:0] acc;
        logic [CNT_W-1:0]     bc;
        logic                 failed;
    } t_word;

    logic [WORD_BITS-1:0] r_acc;
    logic [CNT_W-1:0]     r_bc;
    logic                 r_failed;
    logic [SYM_W-1:0]     r_seen;

    t_word            w0, w1, w2;
    logic [SYM_W-1:0] n_seen;

    function automatic t_word apply(input t_word s, input t_run r);
        t_word                o;
        logic [CNT_W-1:0]     room;
        logic [CNT_W-1:0]     c;
        logic [WORD_BITS-1:0] fill;
        begin
            o    = s;
            room = CNT_W'(WORD_BITS) - s.bc;
            c    = (r.cnt > room) ? room : r.cnt;
            fill = (WORD_BITS'(1) << c) - WORD_BITS'(1);
            if (s.failed || s.bc >= CNT_W'(WORD_BITS)) begin
                o = s;
            end else if (s.bc == '0 && r.level) begin
                o.failed = 1'b1;
            end else begin
                o.acc = (s.acc << c) | (r.level ? fill : '0);
                o.bc  = s.bc + c;
            end
            return o;
        end
    endfunction

    always_comb begin
        w0 = '{acc: r_acc, bc: r_bc, failed: r_failed};
        w1 = i_run_a.zero ? w0 : apply(w0, i_run_a);
        w2 = (i_run_a.zero || i_run_b.zero) ? w1 : apply(w1, i_run_b);
        n_seen = (r_seen == SYM_SAT) ? r_seen : r_seen + SYM_W'(1);
        o_capture.acc    = w2.acc;
        o_capture.bc     = w2.bc;
        o_capture.failed = w2.failed;
        o_capture.echo   = (n_seen == SYM_SAT) || (n_seen > i_max_symbols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_bc     <= '0;
            r_failed <= 1'b0;
            r_seen   <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_acc    <= '0;
                r_bc     <= '0;
                r_failed <= 1'b0;
                r_seen   <= '0;
            end else begin
                r_acc    <= w2.acc;
                r_bc     <= w2.bc;
                r_failed <= w2.failed;
                r_seen   <= n_seen;
            end
        end
    end

endmodule

[rtl/core/dshot_finish.sv]
`timescale 1ns / 1ps

module dshot_finish
    import dshot_pkg::*;
(
    input  t_capture              i_capture,
    output logic [1:0]            o_status,
    output logic [PERIOD_W-1:0]   o_period
);

    logic [CNT_W-1:0]     pad;
    logic [WORD_BITS-1:0] word;
    logic [19:0]          gcr;
    logic [4:0]           dec [4];
    logic [3:0]           ok;
    logic [15:0]          v16;
    logic [11:0]          v12;
    logic [PERIOD_W-1:0]  p;

    assign pad  = CNT_W'(WORD_BITS) - i_capture.bc;
    assign word = (i_capture.acc << pad) | ((WORD_BITS'(1) << pad) - WORD_BITS'(1));
    assign gcr  = 20'(word ^ (word >> 1));

    for (genvar k = 0; k < 4; k++) begin : g_nib
        assign dec[k] = gcr_lookup(gcr[19-5*k -: 5]);
        assign ok[k]  = dec[k][4];
    end

    assign v16 = {dec[0][3:0], dec[1][3:0], dec[2][3:0], dec[3][3:0]};
    assign v12 = v16[15:4];
    assign p   = PERIOD_W'(v12[8:0]) << v12[11:9];

    always_comb begin
        o_status = ST_BAD;
        o_period = '0;
        if (i_capture.echo) begin
            o_status = ST_ECHO;
        end else if (i_capture.failed || i_capture.bc < CNT_W'(5)) begin
            o_status = ST_BAD;
        end else if (ok != 4'hF) begin
            o_status = ST_BAD;
        end else if ((v16[15:12] ^ v16[11:8] ^ v16[7:4] ^ v16[3:0]) != 4'hF) begin
            o_status = ST_BAD;
        end else if (v12 == 12'hFFF) begin
            o_status = ST_STOPPED;
        end else if (p == '0) begin
            o_status = ST_BAD;
        end else begin
            o_status = ST_PERIOD;
            o_period = p;
        end
    end

endmodule
